### sv/abstat_pkg.sv
// Shared widths, reset values, register indexes and control types for the
// audio block statistics unit. No dependencies; every other file imports it.

package abstat_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 24;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int DIV_CNT_W   = $clog2(SAMPLE_BITS);

  localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W   = 3 * SAMPLE_BITS + 2 * COUNT_BITS;
  localparam int OUT_DATA_W  = ((OUT_FLD_W + 7) / 8) * 8;

  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_UPPER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOWER   = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] CENTRE_RESET = SAMPLE_BITS'(32'h0080_0000);
  localparam logic [SAMPLE_BITS-1:0] UPPER_RESET  = SAMPLE_BITS'(32'h0080_1000);
  localparam logic [SAMPLE_BITS-1:0] LOWER_RESET  = SAMPLE_BITS'(32'h007F_F000);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // update the accumulators with the incoming beat
    logic start;    // snapshot the block and load the divider
    logic step;     // one restoring-division step
    logic load;     // copy the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last; // the current step is the final quotient bit
  } sts_t;

endpackage

### sv/audio_block_statistics_unit.sv
// Audio block statistics unit: each accepted sample beat is folded into the running minimum,
// maximum, sum, count, centre-level crossings and out-of-band count (once the count saturates
// it only sets the overflow flag); a beat not flagged last leaves the input ready for the next.
// A beat flagged last closes the block: the mean is then found by a restoring divider that
// settles one quotient bit per cycle, and input stays blocked until the result is loaded, longer
// while an earlier result is still waiting in the output register. Statistics are cleared by a
// first beat or by reset only. Depends on abstat_pkg, abstat_ctrl and abstat_datapath.

module audio_block_statistics_unit import abstat_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // sample_value
  input  logic                   s_tuser,   // block_first
  input  logic                   s_tlast,   // block_last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // min_sample, max_sample, mean_sample, crossing_count, out_of_band_count
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic                   m_tuser    // count_overflow
);

  cmd_t cmd;
  sts_t sts;

  logic [SAMPLE_BITS-1:0] min_sample, max_sample, mean_sample;
  logic [COUNT_BITS-1:0]  crossing_count, out_of_band_count;

  abstat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_last  (s_tlast),
    .m_tready (m_tready),
    .sts      (sts),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  abstat_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .sample            (s_tdata[SAMPLE_BITS-1:0]),
    .first             (s_tuser),
    .cmd               (cmd),
    .sts               (sts),
    .min_sample        (min_sample),
    .max_sample        (max_sample),
    .mean_sample       (mean_sample),
    .crossing_count    (crossing_count),
    .out_of_band_count (out_of_band_count),
    .count_overflow    (m_tuser)
  );

  assign m_tdata = OUT_DATA_W'({out_of_band_count, crossing_count, mean_sample,
                                max_sample, min_sample});

  // The mean of a block always lies between its extremes.
  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (mean_sample >= min_sample) && (mean_sample <= max_sample))
    else $error("mean outside the block's min and max");

  // Closing a block occupies the divider, so the next beat must wait.
  a_last_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input accepted while the divider is busy");

  // A fresh result only appears after the division has run.
  a_result_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result presented without a division");

endmodule

### sv/abstat_ctrl.sv
// Controller state machine for the audio block statistics unit.
// Depends on abstat_pkg; drives the datapath through cmd_t and reads sts_t.

module abstat_ctrl import abstat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic in_last,
  input  logic m_tready,
  input  sts_t sts,
  output logic s_tready,
  output logic m_tvalid,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.accept = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_last) begin
          cmd.start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // Wait here until the previous result has been taken.
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### sv/abstat_datapath.sv
// Datapath of the audio block statistics unit: configuration registers,
// block accumulators, a restoring divider for the mean and the output register.
// Depends on abstat_pkg; sequenced by abstat_ctrl.

module abstat_datapath import abstat_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   first,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic [SAMPLE_BITS-1:0] min_sample,
  output logic [SAMPLE_BITS-1:0] max_sample,
  output logic [SAMPLE_BITS-1:0] mean_sample,
  output logic [COUNT_BITS-1:0]  crossing_count,
  output logic [COUNT_BITS-1:0]  out_of_band_count,
  output logic                   count_overflow
);

  logic [SAMPLE_BITS-1:0] centre_level, band_upper, band_lower;

  logic [SAMPLE_BITS-1:0] run_min, run_min_next;
  logic [SAMPLE_BITS-1:0] run_max, run_max_next;
  logic [SUM_BITS-1:0]    run_sum, run_sum_next;
  logic [COUNT_BITS-1:0]  total, total_next;
  logic [SAMPLE_BITS-1:0] prev, prev_next;
  logic [COUNT_BITS-1:0]  cross_cnt, cross_cnt_next;
  logic [COUNT_BITS-1:0]  oob, oob_next;
  logic                   ovf, ovf_next;

  logic [SAMPLE_BITS-1:0] base_min, base_max, base_prev;
  logic [SUM_BITS-1:0]    base_sum;
  logic [COUNT_BITS-1:0]  base_total, base_cross, base_oob;
  logic                   base_ovf;
  logic                   crossed;

  logic [SAMPLE_BITS-1:0] snap_min, snap_max;
  logic [COUNT_BITS-1:0]  snap_cross, snap_oob;
  logic                   snap_ovf;

  logic [COUNT_BITS-1:0]  div_rem, div_den;
  logic [SAMPLE_BITS-1:0] div_quot;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [COUNT_BITS:0]    div_trial;
  logic                   div_fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_level <= CENTRE_RESET;
      band_upper   <= UPPER_RESET;
      band_lower   <= LOWER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CENTRE_LEVEL: centre_level <= cfg_data;
        REG_BAND_UPPER:   band_upper   <= cfg_data;
        REG_BAND_LOWER:   band_lower   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A first beat restarts the block before the sample itself is counted.
  always_comb begin
    if (first) begin
      base_min   = '1;
      base_max   = '0;
      base_sum   = '0;
      base_total = '0;
      base_prev  = sample;
      base_cross = '0;
      base_oob   = '0;
      base_ovf   = 1'b0;
    end else begin
      base_min   = run_min;
      base_max   = run_max;
      base_sum   = run_sum;
      base_total = total;
      base_prev  = prev;
      base_cross = cross_cnt;
      base_oob   = oob;
      base_ovf   = ovf;
    end

    crossed = ((base_prev < centre_level) && (sample >= centre_level)) ||
              ((base_prev > centre_level) && (sample <= centre_level));

    run_min_next   = base_min;
    run_max_next   = base_max;
    run_sum_next   = base_sum;
    total_next     = base_total;
    prev_next      = base_prev;
    cross_cnt_next = base_cross;
    oob_next       = base_oob;
    ovf_next       = base_ovf;

    // Once the count is saturated a sample only sets the overflow flag and leaves every other statistic untouched.
    if (base_total == COUNT_MAX) begin
      ovf_next = 1'b1;
    end else begin
      if (sample < base_min) run_min_next = sample;
      if (sample > base_max) run_max_next = sample;
      run_sum_next = base_sum + SUM_BITS'(sample);
      total_next   = base_total + COUNT_BITS'(1);
      if (crossed) cross_cnt_next = base_cross + COUNT_BITS'(1);
      if ((sample > band_upper) || (sample < band_lower)) begin
        oob_next = base_oob + COUNT_BITS'(1);
      end
      prev_next = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min   <= '1;
      run_max   <= '0;
      run_sum   <= '0;
      total     <= '0;
      prev      <= '0;
      cross_cnt <= '0;
      oob       <= '0;
      ovf       <= 1'b0;
    end else if (cmd.accept) begin
      run_min   <= run_min_next;
      run_max   <= run_max_next;
      run_sum   <= run_sum_next;
      total     <= total_next;
      prev      <= prev_next;
      cross_cnt <= cross_cnt_next;
      oob       <= oob_next;
      ovf       <= ovf_next;
    end
  end

  // The sum is below count * 2^SAMPLE_BITS, so its upper part is already
  // smaller than the count and the quotient needs only SAMPLE_BITS steps.
  assign div_trial = {div_rem, div_quot[SAMPLE_BITS-1]};
  assign div_fits  = (div_trial >= {1'b0, div_den});
  assign sts.div_last = (div_cnt == DIV_CNT_W'(SAMPLE_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      snap_min   <= run_min_next;
      snap_max   <= run_max_next;
      snap_cross <= cross_cnt_next;
      snap_oob   <= oob_next;
      snap_ovf   <= ovf_next;
      div_rem    <= run_sum_next[SUM_BITS-1:SAMPLE_BITS];
      div_quot   <= run_sum_next[SAMPLE_BITS-1:0];
      div_den    <= total_next;
      div_cnt    <= '0;
    end else if (cmd.step) begin
      if (div_fits) begin
        div_rem <= COUNT_BITS'(div_trial - {1'b0, div_den});
      end else begin
        div_rem <= div_trial[COUNT_BITS-1:0];
      end
      div_quot <= {div_quot[SAMPLE_BITS-2:0], div_fits};
      div_cnt  <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      min_sample        <= snap_min;
      max_sample        <= snap_max;
      mean_sample       <= (div_den == '0) ? '0 : div_quot;
      crossing_count    <= snap_cross;
      out_of_band_count <= snap_oob;
      count_overflow    <= snap_ovf;
    end
  end

endmodule

### tb/tb_audio_block_statistics_unit.sv
// Self-checking testbench for audio_block_statistics_unit: drives sample beats and register
// writes, predicts each block's min, max, mean, crossing and out-of-band counts, and checks
// every result beat. Depends on abstat_pkg and the unit itself.

module tb_audio_block_statistics_unit import abstat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 is not a register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = SAMPLE_BITS + 6;
  localparam int PHASE_BEATS = 172;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] min_smp;
    logic [SAMPLE_BITS-1:0] max_smp;
    logic [SAMPLE_BITS-1:0] mean_smp;
    logic [COUNT_BITS-1:0]  crossings;
    logic [COUNT_BITS-1:0]  outside;
    logic                   overflow;
  } block_stats_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] smp;
    bit                     first;
    bit                     last;
    bit                     typed;
    block_stats_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // sample_value
  logic s_tuser = 1'b0;                 // block_first
  logic s_tlast = 1'b0;                 // block_last
  logic m_tvalid;
  logic m_tready = 1'b0;
  // min_sample, max_sample, mean_sample, crossing_count, out_of_band_count
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;                        // count_overflow

  audio_block_statistics_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // Register copies and block statistics as the unit should hold them.
  logic [SAMPLE_BITS-1:0] centre_lvl = CENTRE_RESET;
  logic [SAMPLE_BITS-1:0] band_hi = UPPER_RESET;
  logic [SAMPLE_BITS-1:0] band_lo = LOWER_RESET;
  logic [SAMPLE_BITS-1:0] blk_min = '1;
  logic [SAMPLE_BITS-1:0] blk_max = '0;
  logic [SUM_BITS-1:0]    blk_sum = '0;
  logic [COUNT_BITS-1:0]  blk_count = '0;
  logic [SAMPLE_BITS-1:0] prev_smp = '0;
  logic [COUNT_BITS-1:0]  cross_cnt = '0;
  logic [COUNT_BITS-1:0]  oob_cnt = '0;
  logic                   ovf_flag = 1'b0;

  block_stats_t expected_stats[$];
  stim_row_t    directed_rows[$];
  int fail_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left = 0;

  function automatic bit fold_beat(input logic [SAMPLE_BITS-1:0] smp, input bit first,
                                   input bit last, output block_stats_t res);
    logic [SUM_BITS-1:0] quot;
    if (first) begin
      blk_min = '1;
      blk_max = '0;
      blk_sum = '0;
      blk_count = '0;
      cross_cnt = '0;
      oob_cnt = '0;
      ovf_flag = 1'b0;
      prev_smp = smp;
    end
    if (blk_count >= COUNT_MAX) begin
      ovf_flag = 1'b1;
    end else begin
      if (smp < blk_min) blk_min = smp;
      if (smp > blk_max) blk_max = smp;
      blk_sum = blk_sum + SUM_BITS'(smp);
      blk_count = blk_count + COUNT_BITS'(1);
      if ((prev_smp < centre_lvl && smp >= centre_lvl) ||
          (prev_smp > centre_lvl && smp <= centre_lvl))
        cross_cnt = cross_cnt + COUNT_BITS'(1);
      if (smp > band_hi || smp < band_lo) oob_cnt = oob_cnt + COUNT_BITS'(1);
      prev_smp = smp;
    end
    quot = (blk_count != 0) ? blk_sum / SUM_BITS'(blk_count) : '0;
    res.min_smp = blk_min;
    res.max_smp = blk_max;
    res.mean_smp = quot[SAMPLE_BITS-1:0];
    res.crossings = cross_cnt;
    res.outside = oob_cnt;
    res.overflow = ovf_flag;
    return last;
  endfunction

  function automatic stim_row_t make_row(input logic [SAMPLE_BITS-1:0] smp, input bit first,
      input bit last, input bit typed, input logic [SAMPLE_BITS-1:0] mn,
      input logic [SAMPLE_BITS-1:0] mx, input logic [SAMPLE_BITS-1:0] mean,
      input logic [COUNT_BITS-1:0] cr, input logic [COUNT_BITS-1:0] oob);
    stim_row_t r;
    r.smp = smp;
    r.first = first;
    r.last = last;
    r.typed = typed;
    r.want = '{min_smp: mn, max_smp: mx, mean_smp: mean, crossings: cr, outside: oob,
               overflow: 1'b0};
    return r;
  endfunction

  // Samples are near centre or band edges (where comparisons turn), extreme or random.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] base;
    longint v;
    case ($urandom_range(0, 5))
      0: base = centre_lvl;
      1: base = band_hi;
      2: base = band_lo;
      3: return $urandom_range(0, 1) ? '1 : '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
    v = longint'(base) + longint'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > longint'({SAMPLE_BITS{1'b1}})) v = longint'({SAMPLE_BITS{1'b1}});
    return SAMPLE_BITS'(v);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic push_beat(input logic [SAMPLE_BITS-1:0] smp, input bit first, input bit last);
    block_stats_t res;
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'(smp);
    s_tuser <= first;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    if (fold_beat(smp, first, last, res)) expected_stats.push_back(res);
  endtask

  task automatic wait_for_results();
    @(negedge clk) s_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_BITS-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_CENTRE_LEVEL: centre_lvl = val;
      REG_BAND_UPPER:   band_hi = val;
      REG_BAND_LOWER:   band_lo = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input int beats);
    int sent;
    int len;
    int kind;
    bit first;
    bit last;
    sent = 0;
    while (sent < beats) begin
      kind = $urandom_range(0, 19);
      len = (kind < 2) ? $urandom_range(1, 120) : $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        if (kind == 19) begin
          // Noise: start and end flags fall anywhere.
          first = ($urandom_range(0, 7) == 0);
          last = ($urandom_range(0, 7) == 0);
        end else begin
          // A block without a start flag carries on from the leftover statistics.
          first = (kind != 18) && (i == 0);
          last = (i == len - 1);
        end
        push_beat(pick_sample(), first, last);
      end
      sent += len;
      if ($urandom_range(0, 29) == 0) wait_for_results();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      stall_left <= $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    block_stats_t got;
    block_stats_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.min_smp = m_tdata[SAMPLE_BITS-1:0];
      got.max_smp = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      got.mean_smp = m_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      got.crossings = m_tdata[3*SAMPLE_BITS+COUNT_BITS-1:3*SAMPLE_BITS];
      got.outside = m_tdata[3*SAMPLE_BITS+2*COUNT_BITS-1:3*SAMPLE_BITS+COUNT_BITS];
      got.overflow = m_tuser;
      if (expected_stats.size() == 0) begin
        $display("%0t: result beat with none expected, data %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = expected_stats.pop_front();
        check_field("min_sample", 32'(want.min_smp), 32'(got.min_smp));
        check_field("max_sample", 32'(want.max_smp), 32'(got.max_smp));
        check_field("mean_sample", 32'(want.mean_smp), 32'(got.mean_smp));
        check_field("crossing_count", 32'(want.crossings), 32'(got.crossings));
        check_field("out_of_band_count", 32'(want.outside), 32'(got.outside));
        check_field("count_overflow", 32'(want.overflow), 32'(got.overflow));
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t row;
    // Beats before any start flag fold onto the reset statistics.
    directed_rows.push_back(make_row(24'h123456, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h876543, 0, 1, 0, 0, 0, 0, 0, 0));
    // One-beat blocks at the extremes, at the centre and on either side of the band edges.
    directed_rows.push_back(make_row(24'h000000, 1, 1, 1, 24'h000000, 24'h000000,
                                     24'h000000, 0, 1));
    directed_rows.push_back(make_row(24'hFFFFFF, 1, 1, 1, 24'hFFFFFF, 24'hFFFFFF,
                                     24'hFFFFFF, 0, 1));
    directed_rows.push_back(make_row(24'h800000, 1, 1, 1, 24'h800000, 24'h800000,
                                     24'h800000, 0, 0));
    directed_rows.push_back(make_row(24'h801000, 1, 1, 1, 24'h801000, 24'h801000,
                                     24'h801000, 0, 0));
    directed_rows.push_back(make_row(24'h801001, 1, 1, 1, 24'h801001, 24'h801001,
                                     24'h801001, 0, 1));
    directed_rows.push_back(make_row(24'h7FF000, 1, 1, 1, 24'h7FF000, 24'h7FF000,
                                     24'h7FF000, 0, 0));
    directed_rows.push_back(make_row(24'h7FEFFF, 1, 1, 1, 24'h7FEFFF, 24'h7FEFFF,
                                     24'h7FEFFF, 0, 1));
    // Landing exactly on the centre counts going up and going down, but not leaving it.
    directed_rows.push_back(make_row(24'h7FFFFF, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h800000, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h800000, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h7FFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h800001, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h800000, 0, 1, 0, 0, 0, 0, 0, 0));
    // Statistics survive a last flag until the next start flag.
    directed_rows.push_back(make_row(24'hABCDEF, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h000001, 0, 1, 0, 0, 0, 0, 0, 0));
    // A start flag in the middle of a block drops what came before it.
    directed_rows.push_back(make_row(24'h555555, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h900000, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(24'h100000, 0, 1, 0, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      push_beat(row.smp, row.first, row.last);
      // A typed-in result replaces the prediction for that beat.
      if (row.typed) expected_stats[expected_stats.size()-1] = row.want;
    end

    for (int p = 0; p < 8; p++) begin
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p) inside
        0, 7: begin
          set_reg(REG_CENTRE_LEVEL, CENTRE_RESET);
          set_reg(REG_BAND_UPPER, UPPER_RESET);
          set_reg(REG_BAND_LOWER, LOWER_RESET);
          set_reg(REG_UNUSED, SAMPLE_BITS'($urandom));
        end
        1: begin
          set_reg(REG_CENTRE_LEVEL, '0);
          set_reg(REG_BAND_UPPER, '1);
          set_reg(REG_BAND_LOWER, '0);
        end
        2: begin
          set_reg(REG_CENTRE_LEVEL, '1);
          set_reg(REG_BAND_UPPER, '0);
          set_reg(REG_BAND_LOWER, '1);
        end
        default: begin
          set_reg(REG_CENTRE_LEVEL, SAMPLE_BITS'($urandom));
          set_reg(REG_BAND_UPPER, SAMPLE_BITS'($urandom));
          set_reg(REG_BAND_LOWER, SAMPLE_BITS'($urandom));
        end
      endcase
      @(negedge clk) cfg_wr_en <= 1'b0;
      if (p == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
        rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
      end
      run_phase(PHASE_BEATS);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### audio_block_statistics_unit.f
sv/abstat_pkg.sv
sv/abstat_ctrl.sv
sv/abstat_datapath.sv
sv/audio_block_statistics_unit.sv
tb/tb_audio_block_statistics_unit.sv
